// File: design/i2crb_pkg.sv
// Package for the I2C register byte master: phase codes, command codes,
// result word type and reset constants. No dependencies.

package i2crb_pkg;

	// Command codes on the func field
	localparam logic [1:0] FUNC_TICK  = 2'd0;
	localparam logic [1:0] FUNC_WRITE = 2'd1;
	localparam logic [1:0] FUNC_READ  = 2'd2;

	// Slave address after reset
	localparam logic [6:0] DEV_ADDR_RESET = 7'd104;

	// Bit appended to the slave address for a read or a write
	localparam logic RW_READ  = 1'b1;
	localparam logic RW_WRITE = 1'b0;

	// Sequencer phases
	typedef enum logic [3:0] {
		PH_IDLE   = 4'd0,
		PH_START1 = 4'd1,
		PH_WDEV   = 4'd2,
		PH_ACK1   = 4'd3,
		PH_WREG   = 4'd4,
		PH_ACK2   = 4'd5,
		PH_WDATA  = 4'd6,
		PH_ACK3   = 4'd7,
		PH_STOPF  = 4'd8,
		PH_STOP1  = 4'd9,
		PH_START2 = 4'd10,
		PH_WDEVR  = 4'd11,
		PH_ACK4   = 4'd12,
		PH_RBYTE  = 4'd13,
		PH_MNACK  = 4'd14
	} phase_t;

	// One result word: pin levels and status for one tick
	typedef struct packed {
		logic       scl_level;
		logic       sda_release;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_data;
		logic       nack_seen;
	} res_t;

endpackage

// File: design/i2crb_channels.sv
// Valid/ready channel interfaces for the I2C register byte master.
// Depends on nothing; payload widths follow the field list.

interface i2crb_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] func;
	logic [7:0] reg_addr;
	logic [7:0] wr_data;
	logic       sda_in;

	modport source (output valid, output func, output reg_addr, output wr_data,
		output sda_in, input ready);
	modport sink (input valid, input func, input reg_addr, input wr_data,
		input sda_in, output ready);
endinterface

interface i2crb_out_if;
	logic       valid;
	logic       ready;
	logic       scl_level;
	logic       sda_release;
	logic       busy_res;
	logic       done_res;
	logic [7:0] read_data;
	logic       nack_seen;

	modport source (output valid, output scl_level, output sda_release,
		output busy_res, output done_res, output read_data, output nack_seen,
		input ready);
	modport sink (input valid, input scl_level, input sda_release,
		input busy_res, input done_res, input read_data, input nack_seen,
		output ready);
endinterface

// File: design/i2c_register_byte_master_core.sv
// Top level of the I2C register byte master: channel handshake, slave
// address register and result register. Depends on i2crb_pkg, the channel
// interfaces and i2crb_seq.
//
// Usage: every word on the input channel is one bus delay tick. It carries
// func (0 tick only, 1 register write, 2 register read), reg_addr, wr_data
// and the sampled SDA level. Each accepted word yields exactly one result
// word: SCL level, SDA drive, busy, done, the last read byte and the NACK
// flag for that tick. A command is taken only while idle; while a
// transaction runs, func is ignored.
// Results are registered, valid after the edge that accepts the word.
// Throughput is one word per cycle while results are taken; the sequencer
// state updates in the same cycle the word is accepted, in one pass of
// logic. When the receiver stalls, the result register holds its word and
// input ready drops until it is taken; a new word enters in the cycle the
// held one leaves. Write the slave address (cfg_wr_en, cfg_wr_data) only
// while idle; the block does not enforce it. Reset clears the sequencer to
// idle, the result register to empty and sets the slave address to 104.

module i2c_register_byte_master_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [6:0]            cfg_wr_data,
	i2crb_in_if.sink              in_ch,
	i2crb_out_if.source           out_ch
);

	logic [6:0]        dev_q;
	logic              accept;
	logic              out_valid_q;
	i2crb_pkg::res_t   res;
	i2crb_pkg::res_t   res_q;

	// Take a word when the result register is empty or being drained
	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign accept      = in_ch.valid && in_ch.ready;

	// Slave address register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dev_q <= i2crb_pkg::DEV_ADDR_RESET;
		else if (cfg_wr_en)
			dev_q <= cfg_wr_data;
	end

	i2crb_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (accept),
		.func     (in_ch.func),
		.reg_addr (in_ch.reg_addr),
		.wr_data  (in_ch.wr_data),
		.sda_in   (in_ch.sda_in),
		.dev_addr (dev_q),
		.res      (res)
	);

	// Result register: load on accept, drop valid when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (accept)
			out_valid_q <= 1'b1;
		else if (out_ch.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept)
			res_q <= res;
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.scl_level   = res_q.scl_level;
	assign out_ch.sda_release = res_q.sda_release;
	assign out_ch.busy_res    = res_q.busy_res;
	assign out_ch.done_res    = res_q.done_res;
	assign out_ch.read_data   = res_q.read_data;
	assign out_ch.nack_seen   = res_q.nack_seen;

	// An accepted word always shows up as a result next cycle
	a_accept_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid_q)
		else $error("accepted word produced no result");

	// Done only inside a transaction
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.done_res) |-> res_q.busy_res)
		else $error("done outside a transaction");

	// Idle ticks leave both lines released
	a_idle_lines: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !res_q.busy_res) |-> (res_q.scl_level && res_q.sda_release))
		else $error("bus driven while idle");

endmodule

// File: design/i2crb_seq.sv
// Transaction sequencer: phase, tick and bit counters, shift register and
// latched command. Depends on i2crb_pkg.

module i2crb_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [1:0]          func,
	input  logic [7:0]          reg_addr,
	input  logic [7:0]          wr_data,
	input  logic                sda_in,
	input  logic [6:0]          dev_addr,
	output i2crb_pkg::res_t     res
);

	i2crb_pkg::phase_t phase_q, ph_a, ph_n, ph_nxt;
	logic [1:0] tick_q, t_a, t_n;
	logic [3:0] bcnt_q, bc_a, bc_n;
	logic [7:0] shift_q, sh_n, sh_in;
	logic       is_read_q, isrd_a;
	logic [7:0] lreg_q, lreg_a;
	logic [7:0] ldata_q, ldata_a;
	logic       nack_q, nack_a, nack_n;
	logic [7:0] recv_q, recv_n;
	logic       cmd;
	logic       advance;
	logic       scl, sdo, busy, done;

	// Command start: an idle tick with a write or read code opens the start
	always_comb begin
		cmd = (phase_q == i2crb_pkg::PH_IDLE) &&
			(func == i2crb_pkg::FUNC_WRITE || func == i2crb_pkg::FUNC_READ);
		ph_a    = cmd ? i2crb_pkg::PH_START1 : phase_q;
		t_a     = cmd ? 2'd0 : tick_q;
		bc_a    = cmd ? 4'd0 : bcnt_q;
		lreg_a  = cmd ? reg_addr : lreg_q;
		ldata_a = cmd ? wr_data : ldata_q;
		isrd_a  = cmd ? (func == i2crb_pkg::FUNC_READ) : is_read_q;
		nack_a  = cmd ? 1'b0 : nack_q;
		sh_in   = {shift_q[6:0], sda_in};
	end

	// Phase that follows the current one
	always_comb begin
		case (ph_a)
			i2crb_pkg::PH_ACK2:  ph_nxt = isrd_a ? i2crb_pkg::PH_STOP1 : i2crb_pkg::PH_WDATA;
			i2crb_pkg::PH_ACK3:  ph_nxt = i2crb_pkg::PH_STOPF;
			i2crb_pkg::PH_STOPF: ph_nxt = i2crb_pkg::PH_IDLE;
			i2crb_pkg::PH_MNACK: ph_nxt = i2crb_pkg::PH_STOPF;
			i2crb_pkg::PH_START1: ph_nxt = i2crb_pkg::PH_WDEV;
			i2crb_pkg::PH_WDEV:  ph_nxt = i2crb_pkg::PH_ACK1;
			i2crb_pkg::PH_ACK1:  ph_nxt = i2crb_pkg::PH_WREG;
			i2crb_pkg::PH_WREG:  ph_nxt = i2crb_pkg::PH_ACK2;
			i2crb_pkg::PH_WDATA: ph_nxt = i2crb_pkg::PH_ACK3;
			i2crb_pkg::PH_STOP1: ph_nxt = i2crb_pkg::PH_START2;
			i2crb_pkg::PH_START2: ph_nxt = i2crb_pkg::PH_WDEVR;
			i2crb_pkg::PH_WDEVR: ph_nxt = i2crb_pkg::PH_ACK4;
			i2crb_pkg::PH_ACK4:  ph_nxt = i2crb_pkg::PH_RBYTE;
			i2crb_pkg::PH_RBYTE: ph_nxt = i2crb_pkg::PH_MNACK;
			default:             ph_nxt = i2crb_pkg::PH_IDLE;
		endcase
	end

	// Next state: tick and bit counting, shifting, acknowledge sampling
	always_comb begin
		ph_n    = ph_a;
		t_n     = t_a + 2'd1;
		bc_n    = bc_a;
		sh_n    = shift_q;
		nack_n  = nack_a;
		recv_n  = recv_q;
		advance = 1'b0;
		case (ph_a)
			i2crb_pkg::PH_START1, i2crb_pkg::PH_START2: begin
				advance = (t_a == 2'd1);
			end
			i2crb_pkg::PH_WDEV, i2crb_pkg::PH_WREG, i2crb_pkg::PH_WDATA,
			i2crb_pkg::PH_WDEVR: begin
				if (t_a == 2'd2) begin
					sh_n    = {shift_q[6:0], 1'b0};
					t_n     = 2'd0;
					bc_n    = bc_a + 4'd1;
					advance = (bc_a >= 4'd7);
				end
			end
			i2crb_pkg::PH_ACK1, i2crb_pkg::PH_ACK2, i2crb_pkg::PH_ACK3,
			i2crb_pkg::PH_ACK4: begin
				if (t_a == 2'd2 && sda_in)
					nack_n = 1'b1;
				advance = (t_a == 2'd3);
			end
			i2crb_pkg::PH_MNACK: begin
				advance = (t_a == 2'd3);
			end
			i2crb_pkg::PH_RBYTE: begin
				if (t_a == 2'd1) begin
					sh_n = sh_in;
					if (bc_a >= 4'd7)
						recv_n = sh_in;
				end
				if (t_a == 2'd2) begin
					t_n     = 2'd0;
					bc_n    = bc_a + 4'd1;
					advance = (bc_a >= 4'd7);
				end
			end
			i2crb_pkg::PH_STOPF, i2crb_pkg::PH_STOP1: begin
				advance = (t_a == 2'd2);
			end
			default: begin
				// idle or an unused code: hold counters, fall back to idle
				ph_n = i2crb_pkg::PH_IDLE;
				t_n  = tick_q;
			end
		endcase
		if (advance) begin
			ph_n = ph_nxt;
			t_n  = 2'd0;
			bc_n = 4'd0;
			case (ph_nxt)
				i2crb_pkg::PH_WDEV:  sh_n = {dev_addr, i2crb_pkg::RW_WRITE};
				i2crb_pkg::PH_WREG:  sh_n = lreg_a;
				i2crb_pkg::PH_WDATA: sh_n = ldata_a;
				i2crb_pkg::PH_WDEVR: sh_n = {dev_addr, i2crb_pkg::RW_READ};
				i2crb_pkg::PH_RBYTE: sh_n = 8'd0;
				default:             ;
			endcase
		end
	end

	// Outputs: pin levels and status for this tick
	always_comb begin
		scl  = 1'b1;
		sdo  = 1'b1;
		busy = 1'b1;
		done = 1'b0;
		case (ph_a)
			i2crb_pkg::PH_START1, i2crb_pkg::PH_START2: begin
				sdo = (t_a == 2'd0);
			end
			i2crb_pkg::PH_WDEV, i2crb_pkg::PH_WREG, i2crb_pkg::PH_WDATA,
			i2crb_pkg::PH_WDEVR: begin
				scl = (t_a == 2'd1);
				sdo = shift_q[7];
			end
			i2crb_pkg::PH_ACK1, i2crb_pkg::PH_ACK2, i2crb_pkg::PH_ACK3,
			i2crb_pkg::PH_ACK4, i2crb_pkg::PH_MNACK: begin
				scl = (t_a == 2'd1 || t_a == 2'd2);
			end
			i2crb_pkg::PH_RBYTE: begin
				scl = (t_a != 2'd2);
			end
			i2crb_pkg::PH_STOPF, i2crb_pkg::PH_STOP1: begin
				scl  = (t_a != 2'd0);
				sdo  = (t_a == 2'd2);
				done = (ph_a == i2crb_pkg::PH_STOPF) && (t_a == 2'd2);
			end
			default: begin
				busy = 1'b0;
			end
		endcase
		res.scl_level   = scl;
		res.sda_release = sdo;
		res.busy_res    = busy;
		res.done_res    = done;
		res.read_data   = recv_n;
		res.nack_seen   = nack_n;
	end

	// Advance the sequencer once per accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= i2crb_pkg::PH_IDLE;
			tick_q    <= 2'd0;
			bcnt_q    <= 4'd0;
			shift_q   <= 8'd0;
			is_read_q <= 1'b0;
			lreg_q    <= 8'd0;
			ldata_q   <= 8'd0;
			nack_q    <= 1'b0;
			recv_q    <= 8'd0;
		end else if (step) begin
			phase_q   <= ph_n;
			tick_q    <= t_n;
			bcnt_q    <= bc_n;
			shift_q   <= sh_n;
			is_read_q <= isrd_a;
			lreg_q    <= lreg_a;
			ldata_q   <= ldata_a;
			nack_q    <= nack_n;
			recv_q    <= recv_n;
		end
	end

	// Bit counter never passes a full byte
	a_bcnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		bcnt_q <= 4'd8)
		else $error("bit counter out of range");

	// Start phases never run past their last tick
	a_start_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == i2crb_pkg::PH_START1 || phase_q == i2crb_pkg::PH_START2)
		|-> tick_q <= 2'd1)
		else $error("start tick overrun");

	// Idle holds the counters at zero
	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == i2crb_pkg::PH_IDLE |-> (tick_q == 2'd0 && bcnt_q == 4'd0))
		else $error("counters not cleared in idle");

endmodule

// File: bench/testbench.sv
// Self-checking bench for i2c_register_byte_master_core: drives bus ticks,
// predicts pin levels and status per tick, compares every result word.
// Depends on i2crb_pkg, the channel interfaces and the core itself.

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int MAX_SHOWN = 10;
	localparam int RANDOM_TICKS = 640;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	// How the slave side answers on sda_in
	typedef enum int {SDA_ACKED, SDA_HIGH, SDA_LOW, SDA_NOISE} sda_mode_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [6:0] cfg_wr_data;

	i2crb_in_if in_ch();
	i2crb_out_if out_ch();

	i2c_register_byte_master_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	// Sequencer mirror
	logic [6:0] dev_addr;
	i2crb_pkg::phase_t bus_phase;
	int unsigned bus_tick;
	logic [3:0] bit_cnt;
	logic [7:0] shift_reg;
	logic [7:0] reg_latch;
	logic [7:0] data_latch;
	logic [7:0] rx_byte;
	logic read_cmd;
	logic nack_flag;

	i2crb_pkg::res_t expected_pins[$];
	int mismatches;
	int words_sent;
	bit gaps_on;
	bit stalls_on;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit is_byte_phase(i2crb_pkg::phase_t p);
		return p inside {i2crb_pkg::PH_WDEV, i2crb_pkg::PH_WREG, i2crb_pkg::PH_WDATA,
			i2crb_pkg::PH_WDEVR};
	endfunction

	// Enter a phase and load the byte it shifts out
	function automatic void enter_phase(i2crb_pkg::phase_t p);
		bus_phase = p;
		bus_tick = 0;
		bit_cnt = '0;
		case (p)
			i2crb_pkg::PH_WDEV: shift_reg = {dev_addr, i2crb_pkg::RW_WRITE};
			i2crb_pkg::PH_WREG: shift_reg = reg_latch;
			i2crb_pkg::PH_WDATA: shift_reg = data_latch;
			i2crb_pkg::PH_WDEVR: shift_reg = {dev_addr, i2crb_pkg::RW_READ};
			i2crb_pkg::PH_RBYTE: shift_reg = '0;
			default: ;
		endcase
	endfunction

	function automatic i2crb_pkg::phase_t follow_phase(i2crb_pkg::phase_t p);
		case (p)
			i2crb_pkg::PH_ACK2:
				return read_cmd ? i2crb_pkg::PH_STOP1 : i2crb_pkg::PH_WDATA;
			i2crb_pkg::PH_STOPF: return i2crb_pkg::PH_IDLE;
			i2crb_pkg::PH_MNACK: return i2crb_pkg::PH_STOPF;
			default: return i2crb_pkg::phase_t'(p + 1);
		endcase
	endfunction

	// Advance the mirror by one bus tick and return the pin word it yields
	function automatic i2crb_pkg::res_t bus_tick_step(logic [1:0] fn, logic [7:0] ra,
			logic [7:0] wd, logic sd);
		i2crb_pkg::res_t r;
		int unsigned t;
		int unsigned len;
		r.scl_level = 1'b1;
		r.sda_release = 1'b1;
		r.busy_res = 1'b0;
		r.done_res = 1'b0;
		len = 0;
		if (bus_phase == i2crb_pkg::PH_IDLE &&
				(fn == i2crb_pkg::FUNC_WRITE || fn == i2crb_pkg::FUNC_READ)) begin
			reg_latch = ra;
			data_latch = wd;
			read_cmd = (fn == i2crb_pkg::FUNC_READ);
			nack_flag = 1'b0;
			enter_phase(i2crb_pkg::PH_START1);
		end
		if (bus_phase != i2crb_pkg::PH_IDLE) begin
			r.busy_res = 1'b1;
			t = bus_tick;
			if (bus_phase inside {i2crb_pkg::PH_START1, i2crb_pkg::PH_START2}) begin
				len = 2;
				r.sda_release = (t == 0);
			end else if (is_byte_phase(bus_phase)) begin
				len = 3;
				r.scl_level = (t == 1);
				r.sda_release = shift_reg[7];
				if (t == 2)
					shift_reg = shift_reg << 1;
			end else if (bus_phase inside {i2crb_pkg::PH_ACK1, i2crb_pkg::PH_ACK2,
					i2crb_pkg::PH_ACK3, i2crb_pkg::PH_ACK4, i2crb_pkg::PH_MNACK}) begin
				len = 4;
				r.scl_level = (t == 1 || t == 2);
				if (t == 2 && bus_phase != i2crb_pkg::PH_MNACK && sd)
					nack_flag = 1'b1;
			end else if (bus_phase == i2crb_pkg::PH_RBYTE) begin
				len = 3;
				r.scl_level = (t != 2);
				if (t == 1) begin
					shift_reg = {shift_reg[6:0], sd};
					if (bit_cnt >= 7)
						rx_byte = shift_reg;
				end
			end else begin
				// stop condition, final or before the repeated start
				len = 3;
				r.scl_level = (t != 0);
				r.sda_release = (t == 2);
				r.done_res = (bus_phase == i2crb_pkg::PH_STOPF && t == 2);
			end
			t++;
			if (t >= len) begin
				if (is_byte_phase(bus_phase) || bus_phase == i2crb_pkg::PH_RBYTE) begin
					bit_cnt++;
					bus_tick = 0;
					if (bit_cnt >= 8)
						enter_phase(follow_phase(bus_phase));
				end else begin
					enter_phase(follow_phase(bus_phase));
				end
			end else begin
				bus_tick = t;
			end
		end
		r.read_data = rx_byte;
		r.nack_seen = nack_flag;
		return r;
	endfunction

	// Slave answer for the next tick, from the phase the mirror is in
	function automatic logic pick_sda(sda_mode_t m);
		case (m)
			SDA_HIGH: return 1'b1;
			SDA_LOW: return 1'b0;
			SDA_NOISE: return 1'($urandom_range(1));
			default: begin
				if (bus_phase inside {i2crb_pkg::PH_ACK1, i2crb_pkg::PH_ACK2,
						i2crb_pkg::PH_ACK3, i2crb_pkg::PH_ACK4})
					return ($urandom_range(19) == 0);
				return 1'($urandom_range(1));
			end
		endcase
	endfunction

	// Mostly no gap, some short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	function automatic void compare_field(string name, logic [7:0] want, logic [7:0] seen);
		if (seen === want)
			return;
		mismatches++;
		if (mismatches <= MAX_SHOWN)
			$display("%0t: %s expected %0h, got %0h", $time, name, want, seen);
	endfunction

	task automatic check_pin_word();
		i2crb_pkg::res_t want;
		if (expected_pins.size() == 0) begin
			mismatches++;
			if (mismatches <= MAX_SHOWN)
				$display("%0t: result word arrived with nothing expected", $time);
			return;
		end
		want = expected_pins.pop_front();
		compare_field("scl_level", 8'(want.scl_level), 8'(out_ch.scl_level));
		compare_field("sda_release", 8'(want.sda_release), 8'(out_ch.sda_release));
		compare_field("busy_res", 8'(want.busy_res), 8'(out_ch.busy_res));
		compare_field("done_res", 8'(want.done_res), 8'(out_ch.done_res));
		compare_field("read_data", want.read_data, out_ch.read_data);
		compare_field("nack_seen", 8'(want.nack_seen), 8'(out_ch.nack_seen));
	endtask

	// Offer one tick word and hold it until taken; called at a falling edge
	task automatic send_tick(logic [1:0] fn, logic [7:0] ra, logic [7:0] wd, logic sd);
		in_ch.valid <= 1'b1;
		in_ch.func <= fn;
		in_ch.reg_addr <= ra;
		in_ch.wr_data <= wd;
		in_ch.sda_in <= sd;
		do
			@(posedge clk);
		while (!in_ch.ready);
		expected_pins.push_back(bus_tick_step(fn, ra, wd, sd));
		words_sent++;
		@(negedge clk);
	endtask

	task automatic maybe_gap();
		int n;
		if (!gaps_on)
			return;
		n = pick_gap();
		if (n == 0)
			return;
		in_ch.valid <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	// Drop valid and wait for every expected word to come back
	task automatic settle();
		in_ch.valid <= 1'b0;
		while (expected_pins.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic set_device_address(logic [6:0] a);
		settle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= a;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		dev_addr = a;
	endtask

	// One command followed by ticks until the sequencer is idle again
	task automatic run_transfer(logic [1:0] fn, logic [7:0] ra, logic [7:0] wd,
			sda_mode_t m, bit noisy_func);
		logic [1:0] f;
		maybe_gap();
		send_tick(fn, ra, wd, pick_sda(m));
		while (bus_phase != i2crb_pkg::PH_IDLE) begin
			maybe_gap();
			f = noisy_func ? 2'($urandom_range(3)) : i2crb_pkg::FUNC_TICK;
			send_tick(f, 8'($urandom), 8'($urandom), pick_sda(m));
		end
	endtask

	task automatic test_idle_ticks();
		send_tick(i2crb_pkg::FUNC_TICK, 8'h00, 8'h00, 1'b0);
		send_tick(i2crb_pkg::FUNC_TICK, 8'hFF, 8'hFF, 1'b1);
		send_tick(FUNC_UNUSED, 8'h00, 8'hFF, 1'b0);
		send_tick(FUNC_UNUSED, 8'hFF, 8'h00, 1'b1);
	endtask

	task automatic test_register_write();
		run_transfer(i2crb_pkg::FUNC_WRITE, 8'h00, 8'hFF, SDA_LOW, 1'b0);
		run_transfer(i2crb_pkg::FUNC_WRITE, 8'hFF, 8'h00, SDA_HIGH, 1'b0);
		run_transfer(i2crb_pkg::FUNC_WRITE, 8'hA5, 8'h5A, SDA_ACKED, 1'b0);
	endtask

	task automatic test_register_read();
		run_transfer(i2crb_pkg::FUNC_READ, 8'h00, 8'h00, SDA_HIGH, 1'b0);
		run_transfer(i2crb_pkg::FUNC_READ, 8'hFF, 8'hFF, SDA_LOW, 1'b0);
		run_transfer(i2crb_pkg::FUNC_READ, 8'h3C, 8'hC3, SDA_ACKED, 1'b0);
		// read byte must survive a write
		run_transfer(i2crb_pkg::FUNC_WRITE, 8'h12, 8'h34, SDA_ACKED, 1'b0);
	endtask

	// Address extremes, run back to back with no idling on either side
	task automatic test_address_extremes();
		gaps_on = 1'b0;
		stalls_on = 1'b0;
		set_device_address(7'd0);
		run_transfer(i2crb_pkg::FUNC_WRITE, 8'h81, 8'h7E, SDA_ACKED, 1'b0);
		run_transfer(i2crb_pkg::FUNC_READ, 8'h7E, 8'h81, SDA_ACKED, 1'b0);
		set_device_address(7'd127);
		run_transfer(i2crb_pkg::FUNC_WRITE, 8'h55, 8'hAA, SDA_ACKED, 1'b0);
		run_transfer(i2crb_pkg::FUNC_READ, 8'hAA, 8'h55, SDA_ACKED, 1'b0);
		set_device_address(i2crb_pkg::DEV_ADDR_RESET);
		gaps_on = 1'b1;
		stalls_on = 1'b1;
	endtask

	task automatic test_ignored_commands();
		run_transfer(i2crb_pkg::FUNC_WRITE, 8'h0F, 8'hF0, SDA_ACKED, 1'b1);
		run_transfer(i2crb_pkg::FUNC_READ, 8'hF0, 8'h0F, SDA_NOISE, 1'b1);
	endtask

	task automatic test_random_traffic();
		int start;
		int r;
		int n;
		logic [6:0] a;
		start = words_sent;
		while (words_sent - start < RANDOM_TICKS) begin
			r = $urandom_range(99);
			if (r < 12) begin
				// new address and a new idling pattern
				n = $urandom_range(4);
				a = (n == 0) ? 7'd0 : (n == 1) ? 7'd127 : 7'($urandom);
				set_device_address(a);
				gaps_on = ($urandom_range(3) != 0);
				stalls_on = ($urandom_range(3) != 0);
			end else if (r < 80) begin
				run_transfer($urandom_range(1) ? i2crb_pkg::FUNC_WRITE : i2crb_pkg::FUNC_READ,
					8'($urandom), 8'($urandom), SDA_ACKED, 1'b0);
			end else if (r < 90) begin
				repeat ($urandom_range(5, 1)) begin
					maybe_gap();
					send_tick($urandom_range(1) ? i2crb_pkg::FUNC_TICK : FUNC_UNUSED,
						8'($urandom), 8'($urandom), 1'($urandom_range(1)));
				end
			end else begin
				run_transfer($urandom_range(1) ? i2crb_pkg::FUNC_WRITE : i2crb_pkg::FUNC_READ,
					8'($urandom), 8'($urandom), SDA_NOISE, 1'b1);
			end
		end
	endtask

	// Result side: check at the rising edge, move ready at the falling edge
	initial begin : result_sink
		int stall;
		stall = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (out_ch.valid && out_ch.ready)
				check_pin_word();
			@(negedge clk);
			if (stall > 0) begin
				stall--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
				stall = stalls_on ? pick_gap() : 0;
			end
		end
	end

	// End the run if neither channel moves a word for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Verification failed");
		$finish;
	end

	initial begin : stimulus
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_ch.valid = 1'b0;
		in_ch.func = i2crb_pkg::FUNC_TICK;
		in_ch.reg_addr = '0;
		in_ch.wr_data = '0;
		in_ch.sda_in = 1'b1;
		dev_addr = i2crb_pkg::DEV_ADDR_RESET;
		bus_phase = i2crb_pkg::PH_IDLE;
		bus_tick = 0;
		bit_cnt = '0;
		shift_reg = '0;
		reg_latch = '0;
		data_latch = '0;
		rx_byte = '0;
		read_cmd = 1'b0;
		nack_flag = 1'b0;
		mismatches = 0;
		words_sent = 0;
		gaps_on = 1'b1;
		stalls_on = 1'b1;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_idle_ticks();
		test_register_write();
		test_register_read();
		test_address_extremes();
		test_ignored_commands();
		test_random_traffic();

		settle();
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// File: i2c_register_byte_master_core.f
design/i2crb_pkg.sv
design/i2crb_channels.sv
design/i2crb_seq.sv
design/i2c_register_byte_master_core.sv
bench/testbench.sv
